// ----- design/serial_hex_word_loader_macros.svh -----
// ----------------------------------------------------------------------------
// Serial hex word loader assertion macros
// Concurrent check helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SERIAL_HEX_WORD_LOADER_MACROS_SVH
`define SERIAL_HEX_WORD_LOADER_MACROS_SVH

`ifndef SYNTHESIS
`define SHWL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shwl check failed");
`define SHWL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shwl check failed");
`else
`define SHWL_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SHWL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/shwl_pkg.sv -----
// ----------------------------------------------------------------------------
// Serial hex word loader package
// Shared types, character codes and action codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package shwl_pkg;

  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChEq    = 8'h3d;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChS     = 8'h73;
  localparam logic [7:0] ChG     = 8'h67;

  localparam logic [1:0] ActWrite = 2'd0;
  localparam logic [1:0] ActClear = 2'd1;
  localparam logic [1:0] ActDump  = 2'd2;
  localparam logic [1:0] ActStart = 2'd3;

  localparam logic RegRamBase = 1'b0;
  localparam logic RegRamEnd  = 1'b1;

  localparam logic [15:0] DumpAlignMask = 16'hfff0;
  localparam logic [16:0] AddrTop       = 17'h10000;

  typedef enum logic [1:0] {
    PhIdle,
    PhToken,
    PhStarted
  } phase_e;

  typedef enum logic [1:0] {
    KindData,
    KindLoad,
    KindBreak
  } kind_e;

  typedef struct packed {
    phase_e      phase;
    kind_e       kind;
    logic [15:0] accum;
    logic [15:0] load_addr;
    logic [15:0] break_addr;
    logic [16:0] low_mark;
    logic [15:0] high_mark;
    logic [1:0]  dot_run;
  } state_t;

  typedef struct packed {
    logic [15:0] ram_base;
    logic [16:0] ram_end;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] mem_address;
    logic [7:0]  mem_data;
    logic [15:0] dump_start;
    logic [15:0] dump_end;
    logic        step_mode;
    logic [15:0] break_at;
    logic        last;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t        h;
    logic [7:0]  diff;
    h    = '0;
    diff = '0;
    if (c inside {[8'h30:8'h39]}) begin
      diff = c - 8'h30;
      h.valid = 1'b1;
    end else if (c inside {[8'h41:8'h46]}) begin
      diff = c - 8'h37;
      h.valid = 1'b1;
    end else if (c inside {[8'h61:8'h66]}) begin
      diff = c - 8'h57;
      h.valid = 1'b1;
    end
    h.value = diff[3:0];
    return h;
  endfunction

endpackage

// ----- design/serial_hex_word_loader.sv -----
// ----------------------------------------------------------------------------
// Serial hex word loader
// Loader command parser: one received character in, memory actions out.
// ----------------------------------------------------------------------------
// A character is registered on transfer and parsed in the following cycle,
// provided the two-entry result buffer is drained by then. Characters that
// cause no result or one result are taken one per cycle while the output
// is not stalled; a data word terminator or unrecognised character emits
// two byte writes if the load address is in the RAM window, and the next
// character waits until the first is taken, the buffer draining one result
// per unstalled cycle. After a start action every further character is
// consumed with no result until reset. The configuration port never stalls.
`timescale 1ns / 1ps
`include "serial_hex_word_loader_macros.svh"

module serial_hex_word_loader (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_char_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  action_o,
  output logic [15:0] mem_address_o,
  output logic [7:0]  mem_data_o,
  output logic [15:0] dump_start_o,
  output logic [15:0] dump_end_o,
  output logic        step_mode_o,
  output logic [15:0] break_at_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  shwl_pkg::state_t  state_q, state_d;
  shwl_pkg::cfg_t    cfg_q;
  shwl_pkg::result_t res0, res1;
  shwl_pkg::result_t slot_q [2];
  logic [1:0]        res_count;
  logic [1:0]        count_q;
  logic              char_valid_q;
  logic [7:0]        char_q;
  logic              pop;
  logic              fire;
  logic              in_take;

  shwl_step u_step (
    .char_i  (char_q),
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .state_o (state_d),
    .res0_o  (res0),
    .res1_o  (res1),
    .count_o (res_count)
  );

  assign pop         = (count_q != 2'd0) && !out_stall_i;
  assign fire        = char_valid_q && ((count_q == 2'd0) || (count_q == 2'd1 && pop));
  assign in_stall_o  = char_valid_q && !fire;
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ram_base <= '0;
      cfg_q.ram_end  <= shwl_pkg::AddrTop;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        shwl_pkg::RegRamBase: cfg_q.ram_base <= cfg_data_i[15:0];
        shwl_pkg::RegRamEnd:  cfg_q.ram_end  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase      <= shwl_pkg::PhIdle;
      state_q.kind       <= shwl_pkg::KindData;
      state_q.accum      <= '0;
      state_q.load_addr  <= '0;
      state_q.break_addr <= '0;
      state_q.low_mark   <= shwl_pkg::AddrTop;
      state_q.high_mark  <= '0;
      state_q.dot_run    <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_valid_q <= 1'b0;
    end else if (in_take) begin
      char_valid_q <= 1'b1;
    end else if (fire) begin
      char_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      char_q <= rx_char_i;
    end
  end

  // Hold results; the head is always slot 0.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (fire) begin
      count_q <= res_count;
    end else if (pop) begin
      count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      slot_q[0] <= res0;
      slot_q[1] <= res1;
    end else if (pop) begin
      slot_q[0] <= slot_q[1];
    end
  end

  assign out_valid_o   = (count_q != 2'd0);
  assign action_o      = slot_q[0].action;
  assign mem_address_o = slot_q[0].mem_address;
  assign mem_data_o    = slot_q[0].mem_data;
  assign dump_start_o  = slot_q[0].dump_start;
  assign dump_end_o    = slot_q[0].dump_end;
  assign step_mode_o   = slot_q[0].step_mode;
  assign break_at_o    = slot_q[0].break_at;
  assign last_o        = slot_q[0].last;

  `SHWL_ASSERT_SAME(a_fire_room, clk_i, rst_ni, fire, (count_q == 2'd0) || pop)
  `SHWL_ASSERT_SAME(a_pair_head_not_last, clk_i, rst_ni, count_q == 2'd2, !slot_q[0].last)
  `SHWL_ASSERT_SAME(a_started_silent, clk_i, rst_ni,
    fire && (state_q.phase == shwl_pkg::PhStarted), res_count == 2'd0)
  `SHWL_ASSERT_NEXT(a_start_latches, clk_i, rst_ni,
    fire && (res_count == 2'd1) && (res0.action == shwl_pkg::ActStart),
    state_q.phase == shwl_pkg::PhStarted)

endmodule

// ----- design/shwl_step.sv -----
// ----------------------------------------------------------------------------
// Serial hex word loader step logic
// Parses one character against the current state and forms up to two results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shwl_step (
  input  logic [7:0]       char_i,
  input  shwl_pkg::state_t state_i,
  input  shwl_pkg::cfg_t   cfg_i,
  output shwl_pkg::state_t state_o,
  output shwl_pkg::result_t res0_o,
  output shwl_pkg::result_t res1_o,
  output logic [1:0]       count_o
);

  shwl_pkg::hex_t    hex;
  shwl_pkg::state_t  st;
  shwl_pkg::result_t r0;
  shwl_pkg::result_t r1;
  logic [1:0]        n;
  logic              word_en;
  logic [15:0]       word;
  logic [15:0]       addr;
  logic [15:0]       addr_next;
  logic              in_window;

  always_comb begin
    hex       = shwl_pkg::hex_decode(char_i);
    st        = state_i;
    r0        = '0;
    r1        = '0;
    n         = 2'd0;
    word_en   = 1'b0;
    word      = state_i.accum;
    addr      = state_i.load_addr;
    addr_next = state_i.load_addr + 16'd2;
    in_window = (cfg_i.ram_base <= addr) && ({1'b0, addr} < cfg_i.ram_end);

    if (state_i.phase == shwl_pkg::PhStarted) begin
      n = 2'd0;
    end else if (char_i == shwl_pkg::ChDot) begin
      if (state_i.dot_run == 2'd2) begin
        st.dot_run     = 2'd0;
        st.phase       = shwl_pkg::PhStarted;
        r0.action      = shwl_pkg::ActStart;
        r0.break_at    = state_i.break_addr;
        n              = 2'd1;
      end else begin
        st.dot_run = state_i.dot_run + 2'd1;
      end
    end else begin
      st.dot_run = 2'd0;
      if (state_i.phase == shwl_pkg::PhToken) begin
        if (hex.valid) begin
          st.accum = {state_i.accum[11:0], hex.value};
        end else begin
          st.phase = shwl_pkg::PhIdle;
          case (state_i.kind)
            shwl_pkg::KindLoad:  st.load_addr  = state_i.accum;
            shwl_pkg::KindBreak: st.break_addr = state_i.accum;
            default:             word_en       = 1'b1;
          endcase
        end
      end else if (char_i inside {shwl_pkg::ChSpace, shwl_pkg::ChTab,
                                  shwl_pkg::ChLf, shwl_pkg::ChCr}) begin
        n = 2'd0;
      end else if (char_i == shwl_pkg::ChBang &&
                   state_i.low_mark < {1'b0, state_i.high_mark}) begin
        r0.action     = shwl_pkg::ActDump;
        r0.dump_start = state_i.low_mark[15:0] & shwl_pkg::DumpAlignMask;
        r0.dump_end   = state_i.high_mark;
        n             = 2'd1;
      end else if (char_i == shwl_pkg::ChS || char_i == shwl_pkg::ChG) begin
        st.phase     = shwl_pkg::PhStarted;
        r0.action    = shwl_pkg::ActStart;
        r0.step_mode = (char_i == shwl_pkg::ChS);
        r0.break_at  = state_i.break_addr;
        n            = 2'd1;
      end else if (char_i == shwl_pkg::ChComma) begin
        r0.action = shwl_pkg::ActClear;
        n         = 2'd1;
      end else if (char_i == shwl_pkg::ChEq || char_i == shwl_pkg::ChPct) begin
        st.phase = shwl_pkg::PhToken;
        st.kind  = (char_i == shwl_pkg::ChEq) ? shwl_pkg::KindLoad : shwl_pkg::KindBreak;
        st.accum = '0;
      end else if (hex.valid) begin
        st.phase = shwl_pkg::PhToken;
        st.kind  = shwl_pkg::KindData;
        st.accum = {12'd0, hex.value};
      end else begin
        st.accum = '0;
        word     = '0;
        word_en  = 1'b1;
      end
    end

    if (word_en && in_window) begin
      r0.action      = shwl_pkg::ActWrite;
      r0.mem_address = addr;
      r0.mem_data    = word[15:8];
      r1.action      = shwl_pkg::ActWrite;
      r1.mem_address = addr + 16'd1;
      r1.mem_data    = word[7:0];
      n              = 2'd2;
      st.load_addr   = addr_next;
      if (state_i.high_mark < addr_next) begin
        st.high_mark = addr_next;
      end
      if ({1'b0, addr} < state_i.low_mark) begin
        st.low_mark = {1'b0, addr};
      end
    end

    r0.last = (n == 2'd1);
    r1.last = 1'b1;
  end

  assign state_o = st;
  assign res0_o  = r0;
  assign res1_o  = r1;
  assign count_o = n;

endmodule

// ----- bench/shwl_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// Serial hex word loader bench constants
// Register indexes shared by the stimulus top and the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package shwl_tb_pkg;

  localparam logic RegRamBase = 1'b0;
  localparam logic RegRamEnd  = 1'b1;

endpackage

// ----- bench/serial_hex_word_loader_checker.sv -----
// ----------------------------------------------------------------------------
// Serial hex word loader checker
// Watches the character, action and register channels, runs its own parser
// model on every accepted character and register write, and compares each
// action transfer field by field with the oldest predicted action.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_hex_word_loader_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  rx_char_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  action_i,
  input  logic [15:0] mem_address_i,
  input  logic [7:0]  mem_data_i,
  input  logic [15:0] dump_start_i,
  input  logic [15:0] dump_end_i,
  input  logic        step_mode_i,
  input  logic [15:0] break_at_i,
  input  logic        last_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [16:0] cfg_data_i,
  output int          mismatches_o,
  output int          outstanding_o
);

  shwl_pkg::phase_e  parse_state;
  shwl_pkg::kind_e   tok_kind;
  logic [15:0]       word_acc;
  logic [15:0]       load_ptr;
  logic [15:0]       break_ptr;
  logic [16:0]       mark_lo;
  logic [15:0]       mark_hi;
  logic [1:0]        dot_count;
  logic [15:0]       win_base;
  logic [16:0]       win_end;

  shwl_pkg::result_t pending_actions[$];
  shwl_pkg::result_t got_action;
  shwl_pkg::result_t want_action;
  int                mismatches = 0;

  assign mismatches_o = mismatches;

  function automatic shwl_pkg::result_t blank_action(input logic [1:0] act);
    shwl_pkg::result_t r;
    r        = '0;
    r.action = act;
    return r;
  endfunction

  function automatic string describe(input shwl_pkg::result_t r);
    return $sformatf("act=%0d addr=%h data=%h dump=%h..%h step=%b brk=%h last=%b",
                     r.action, r.mem_address, r.mem_data, r.dump_start, r.dump_end,
                     r.step_mode, r.break_at, r.last);
  endfunction

  function automatic void log_mismatch(input string msg);
    mismatches = mismatches + 1;
    if (mismatches <= 10) begin
      $display("%t checker: %s", $realtime, msg);
    end
  endfunction

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  function automatic int emit_word();
    shwl_pkg::result_t r;
    logic [15:0]       a;
    a = load_ptr;
    if (!(win_base <= a && {1'b0, a} < win_end)) return 0;
    r             = blank_action(shwl_pkg::ActWrite);
    r.mem_address = a;
    r.mem_data    = word_acc[15:8];
    pending_actions.push_back(r);
    r.mem_address = a + 16'd1;
    r.mem_data    = word_acc[7:0];
    pending_actions.push_back(r);
    load_ptr = a + 16'd2;
    if (mark_hi < load_ptr) mark_hi = load_ptr;
    if ({1'b0, a} < mark_lo) mark_lo = {1'b0, a};
    return 2;
  endfunction

  function automatic int launch(input logic step);
    shwl_pkg::result_t r;
    parse_state = shwl_pkg::PhStarted;
    r           = blank_action(shwl_pkg::ActStart);
    r.step_mode = step;
    r.break_at  = break_ptr;
    pending_actions.push_back(r);
    return 1;
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    int                n;
    logic [4:0]        h;
    shwl_pkg::result_t r;
    n = 0;
    if (parse_state == shwl_pkg::PhStarted) return;
    h = nibble_of(c);
    if (c == shwl_pkg::ChDot) begin
      dot_count = dot_count + 2'd1;
      if (dot_count == 2'd3) begin
        dot_count = '0;
        n = launch(1'b0);
      end
    end else begin
      dot_count = '0;
      if (parse_state == shwl_pkg::PhToken) begin
        if (h[4]) begin
          word_acc = {word_acc[11:0], h[3:0]};
        end else begin
          parse_state = shwl_pkg::PhIdle;
          case (tok_kind)
            shwl_pkg::KindLoad:  load_ptr = word_acc;
            shwl_pkg::KindBreak: break_ptr = word_acc;
            default:             n = emit_word();
          endcase
        end
      end else if (c == shwl_pkg::ChSpace || c == shwl_pkg::ChTab ||
                   c == shwl_pkg::ChLf || c == shwl_pkg::ChCr) begin
        n = 0;
      end else if (c == shwl_pkg::ChBang && mark_lo < {1'b0, mark_hi}) begin
        r            = blank_action(shwl_pkg::ActDump);
        r.dump_start = mark_lo[15:0] & shwl_pkg::DumpAlignMask;
        r.dump_end   = mark_hi;
        pending_actions.push_back(r);
        n = 1;
      end else if (c == shwl_pkg::ChS) begin
        n = launch(1'b1);
      end else if (c == shwl_pkg::ChG) begin
        n = launch(1'b0);
      end else if (c == shwl_pkg::ChComma) begin
        pending_actions.push_back(blank_action(shwl_pkg::ActClear));
        n = 1;
      end else if (c == shwl_pkg::ChEq || c == shwl_pkg::ChPct) begin
        parse_state = shwl_pkg::PhToken;
        tok_kind    = (c == shwl_pkg::ChEq) ? shwl_pkg::KindLoad : shwl_pkg::KindBreak;
        word_acc    = '0;
      end else if (h[4]) begin
        parse_state = shwl_pkg::PhToken;
        tok_kind    = shwl_pkg::KindData;
        word_acc    = {12'd0, h[3:0]};
      end else begin
        word_acc = '0;
        n = emit_word();
      end
    end
    if (n > 0) begin
      r = pending_actions.pop_back();
      r.last = 1'b1;
      pending_actions.push_back(r);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_state = shwl_pkg::PhIdle;
      tok_kind    = shwl_pkg::KindData;
      word_acc    = '0;
      load_ptr    = '0;
      break_ptr   = '0;
      mark_lo     = shwl_pkg::AddrTop;
      mark_hi     = '0;
      dot_count   = '0;
      win_base    = '0;
      win_end     = shwl_pkg::AddrTop;
      pending_actions.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == shwl_tb_pkg::RegRamBase) win_base = cfg_data_i[15:0];
        else win_end = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) parse_char(rx_char_i);
      if (out_valid_i && !out_stall_i) begin
        got_action.action      = action_i;
        got_action.mem_address = mem_address_i;
        got_action.mem_data    = mem_data_i;
        got_action.dump_start  = dump_start_i;
        got_action.dump_end    = dump_end_i;
        got_action.step_mode   = step_mode_i;
        got_action.break_at    = break_at_i;
        got_action.last        = last_i;
        if (pending_actions.size() == 0) begin
          log_mismatch({"unexpected action ", describe(got_action)});
        end else begin
          want_action = pending_actions.pop_front();
          if (got_action.action !== want_action.action ||
              got_action.mem_address !== want_action.mem_address ||
              got_action.mem_data !== want_action.mem_data ||
              got_action.dump_start !== want_action.dump_start ||
              got_action.dump_end !== want_action.dump_end ||
              got_action.step_mode !== want_action.step_mode ||
              got_action.break_at !== want_action.break_at ||
              got_action.last !== want_action.last) begin
            log_mismatch({"expected ", describe(want_action),
                          " got ", describe(got_action)});
          end
        end
      end
    end
    outstanding_o = pending_actions.size();
  end

endmodule

// ----- bench/serial_hex_word_loader_tb.sv -----
// ----------------------------------------------------------------------------
// Serial hex word loader testbench
// Feeds loader command text: a short directed script, then mostly well-formed
// address, break and data tokens with random content under several RAM
// windows, mixed with commands, dots and noise bytes, and ends with a start.
// Both channels idle at random and the receiver holds off once for long.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_hex_word_loader_tb;

  localparam int CycleLimit    = 400000;
  localparam int DrainCycles   = 8;
  localparam int PhaseItems    = 80;
  localparam int SqueezeCycles = 120;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_char = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  action;
  logic [15:0] mem_address;
  logic [7:0]  mem_data;
  logic [15:0] dump_start;
  logic [15:0] dump_end;
  logic        step_mode;
  logic [15:0] break_at;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = shwl_tb_pkg::RegRamBase;
  logic [16:0] cfg_data = '0;

  int          mismatches;
  int          outstanding;
  int          cycle_count = 0;
  int          dot_streak = 0;
  int          sent_count = 0;
  int          calm_items = 0;
  bit          squeeze_armed = 1'b0;
  bit          squeeze_done = 1'b0;
  logic [15:0] cur_base = '0;
  logic [16:0] cur_end = shwl_pkg::AddrTop;

  serial_hex_word_loader dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .rx_char_i     (rx_char),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .action_o      (action),
    .mem_address_o (mem_address),
    .mem_data_o    (mem_data),
    .dump_start_o  (dump_start),
    .dump_end_o    (dump_end),
    .step_mode_o   (step_mode),
    .break_at_o    (break_at),
    .last_o        (last),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  serial_hex_word_loader_checker check_unit (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .rx_char_i     (rx_char),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .action_i      (action),
    .mem_address_i (mem_address),
    .mem_data_i    (mem_data),
    .dump_start_i  (dump_start),
    .dump_end_i    (dump_end),
    .step_mode_i   (step_mode),
    .break_at_i    (break_at),
    .last_i        (last),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm_items > 0) begin
      calm_items = calm_items - 1;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) calm_items = 20;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic int pick_free();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 6);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] w;
    w = {4'd0, v};
    if (v < 4'd10) return "0" + w;
    return ($urandom_range(0, 1) ? "a" : "A") + w - 8'd10;
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0:       return shwl_pkg::ChSpace;
      1:       return shwl_pkg::ChTab;
      2:       return shwl_pkg::ChLf;
      default: return shwl_pkg::ChCr;
    endcase
  endfunction

  function automatic logic [7:0] pick_noise();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == shwl_pkg::ChS || c == shwl_pkg::ChG ||
               (c == shwl_pkg::ChDot && dot_streak >= 2));
    return c;
  endfunction

  function automatic logic [7:0] pick_terminator();
    if ($urandom_range(0, 4) != 0) return pick_blank();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(8'h80, 8'hff));
      1:       return shwl_pkg::ChBang;
      2:       return shwl_pkg::ChComma;
      default: return shwl_pkg::ChEq;
    endcase
  endfunction

  function automatic logic [15:0] pick_addr();
    int lo;
    int hi;
    lo = int'(cur_base);
    hi = int'(cur_end) - 1;
    if (lo > hi || $urandom_range(0, 7) == 0) return 16'($urandom);
    case ($urandom_range(0, 3))
      0:       return 16'(lo);
      1:       return 16'(hi);
      2:       return 16'((hi - 1 < lo) ? lo : hi - 1);
      default: return 16'($urandom_range(hi, lo));
    endcase
  endfunction

  task automatic send_char(input logic [7:0] c);
    int gap;
    in_valid <= 1'b1;
    rx_char  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    dot_streak = (c == shwl_pkg::ChDot) ? dot_streak + 1 : 0;
    sent_count = sent_count + 1;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_hex(input logic [19:0] val, input int digits);
    for (int i = digits - 1; i >= 0; i--) begin
      send_char(hex_char(val[4*i +: 4]));
      if (i > 0 && $urandom_range(0, 15) == 0) send_char(shwl_pkg::ChDot);
    end
  endtask

  task automatic set_window(input logic [15:0] base, input logic [16:0] lim);
    cfg_valid <= 1'b1;
    cfg_index <= shwl_tb_pkg::RegRamBase;
    cfg_data  <= {1'b0, base};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= shwl_tb_pkg::RegRamEnd;
    cfg_data  <= lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_base = base;
    cur_end  = lim;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic random_traffic(input int count);
    int stop_at;
    int kind;
    stop_at = sent_count + count;
    while (sent_count < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        send_hex(20'($urandom), ($urandom_range(0, 9) == 0) ? 5 : $urandom_range(1, 4));
        send_char(pick_terminator());
      end else if (kind < 50) begin
        send_char(shwl_pkg::ChEq);
        send_hex({4'd0, pick_addr()}, 4);
        send_char(pick_terminator());
      end else if (kind < 58) begin
        send_char(shwl_pkg::ChPct);
        send_hex(20'($urandom), $urandom_range(1, 4));
        send_char(pick_terminator());
      end else if (kind < 66) begin
        send_char(shwl_pkg::ChBang);
      end else if (kind < 71) begin
        send_char(shwl_pkg::ChComma);
      end else if (kind < 79) begin
        send_char(pick_blank());
      end else if (kind < 85) begin
        if (dot_streak < 2) send_char(shwl_pkg::ChDot);
      end else begin
        send_char(pick_noise());
      end
    end
  endtask

  initial begin
    int n;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (squeeze_armed && !squeeze_done) begin
        squeeze_done = 1'b1;
        out_stall <= 1'b1;
        repeat (SqueezeCycles) @(posedge clk);
      end
      n = pick_stall();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (pick_free()) @(posedge clk);
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_window(16'h0000, shwl_pkg::AddrTop);

    send_text("=fffe ");
    send_text("A5c3.\n");
    send_text("%9B!");
    send_text("!");
    send_text("12345\r");
    send_text("!");
    send_text(",");
    send_char(8'hff);
    send_char(8'h00);
    drain_results();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       set_window(16'h0000, 17'h00001);
        1:       set_window(16'hffff, shwl_pkg::AddrTop);
        2:       set_window(16'h1000, 17'h01100);
        3:       set_window(16'h8000, 17'h00100);
        4:       set_window(16'($urandom), 17'($urandom_range(1, 65536)));
        default: set_window(16'h0000, shwl_pkg::AddrTop);
      endcase
      if (ph == 5) squeeze_armed = 1'b1;
      random_traffic(PhaseItems);
      drain_results();
    end

    send_char(shwl_pkg::ChSpace);
    case ($urandom_range(0, 2))
      0:       send_char(shwl_pkg::ChS);
      1:       send_char(shwl_pkg::ChG);
      default: repeat (3) send_char(shwl_pkg::ChDot);
    endcase
    repeat (6) send_char(8'($urandom_range(0, 255)));
    drain_results();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
